@@ hdl/rcfd_pkg.sv @@
// Package: widths, codes and the result record of the remote-control frame decoder.
`default_nettype none
package rcfd_pkg;

   // Frame geometry and default buffer size
   localparam int FRAME_BYTES         = 18;
   localparam int RX_BUFFER_BYTES_DEF = 32;
   localparam int FRAME_IDX_W         = $clog2(FRAME_BYTES);

   // Field widths
   localparam int FUNC_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int CH_W      = 11;
   localparam int OUT_W     = 12;
   localparam int SWITCH_W  = 2;
   localparam int AGE_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Register reset values and saturation limit
   localparam logic [CH_W-1:0]  CENTER_RESET  = 11'd1024;
   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;

   // Event codes carried in func
   typedef enum logic [FUNC_W-1:0] {
      FUNC_BYTE = 2'd0,
      FUNC_IDLE = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_VALUE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFLINE_TIMEOUT = 1'd1;

   // One result record
   typedef struct packed {
      logic                     frame_new;
      logic                     online;
      logic signed [OUT_W-1:0]  stick_zero;
      logic signed [OUT_W-1:0]  stick_one;
      logic signed [OUT_W-1:0]  stick_two;
      logic signed [OUT_W-1:0]  stick_three;
      logic [SWITCH_W-1:0]      switch_left;
      logic [SWITCH_W-1:0]      switch_right;
      logic signed [OUT_W-1:0]  dial_value;
   } rsp_payload_type;

endpackage
`default_nettype wire

@@ hdl/rcfd_req_if.sv @@
// Interface: input event channel (valid/ready with func and byte payload).
`default_nettype none
interface rcfd_req_if import rcfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] byte_value;

   modport source (output valid, output func, output byte_value, input ready);
   modport sink   (input valid, input func, input byte_value, output ready);
endinterface
`default_nettype wire

@@ hdl/rcfd_rsp_if.sv @@
// Interface: decoded result channel (valid/ready with status and channel values).
`default_nettype none
interface rcfd_rsp_if import rcfd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    frame_new;
   logic                    online;
   logic signed [OUT_W-1:0] stick_zero;
   logic signed [OUT_W-1:0] stick_one;
   logic signed [OUT_W-1:0] stick_two;
   logic signed [OUT_W-1:0] stick_three;
   logic [SWITCH_W-1:0]     switch_left;
   logic [SWITCH_W-1:0]     switch_right;
   logic signed [OUT_W-1:0] dial_value;

   modport source (output valid, output frame_new, output online, output stick_zero,
                   output stick_one, output stick_two, output stick_three,
                   output switch_left, output switch_right, output dial_value,
                   input ready);
   modport sink   (input valid, input frame_new, input online, input stick_zero,
                   input stick_one, input stick_two, input stick_three,
                   input switch_left, input switch_right, input dial_value,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/rc_frame_receiver_decoder_unit.sv @@
// Top level: remote-control frame receiver and decoder with a two-entry result buffer.
//
// Usage: req_chan carries one event per transfer: a received UART byte, a line-idle
// event that closes a burst, or a time tick. A burst of exactly FRAME_BYTES bytes is
// decoded at its idle event into four centred sticks, two switch codes and a centred
// dial; these are held and reported with every result. rsp_chan returns exactly one
// result per input transfer, in order, with frame_new and the online flag.
// Output: each result is registered, in the result register or, while a result waits, in the skid register.
// Throughput: one item per cycle while req_chan.ready is high; all decode work is one
// pass of logic between the accepting edge and the result or skid register.
// Stall: a two-entry output buffer (result register plus skid register) lets one more
// item enter while a result waits; req_chan.ready drops only when both are full.
// Reset: synchronous, active high; clears the burst count, the silence age, the held
// values and the buffer, and loads center_value = 1024, offline_timeout = 100.
// csr_* writes take effect at the edge where csr_we is high; write only while idle.
`default_nettype none
module rc_frame_receiver_decoder_unit import rcfd_pkg::*; #(
   parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rcfd_req_if.sink                  req_chan,
   rcfd_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CountW = $clog2(RX_BUFFER_BYTES + 1);
   localparam logic [CountW-1:0] CountFrame = CountW'(FRAME_BYTES);
   localparam logic [CountW-1:0] CountFull  = CountW'(RX_BUFFER_BYTES);

   // Configuration registers
   logic [CH_W-1:0]  center_ff;
   logic [AGE_W-1:0] timeout_ff;

   // Block state
   logic [BYTE_W-1:0]       frame_ff [FRAME_BYTES];
   logic [CountW-1:0]       burst_ff, burst_in;
   logic [AGE_W-1:0]        age_ff, age_in;
   logic signed [OUT_W-1:0] stick_ff [4];
   logic [2*SWITCH_W-1:0]   switches_ff;
   logic signed [OUT_W-1:0] dial_ff;

   // Result buffer
   logic            out_valid_ff, skid_valid_ff;
   rsp_payload_type out_ff, skid_ff, result_in;

   logic push, pop, byte_wr, decode;
   func_type func;

   logic [CH_W-1:0]         raw [4];
   logic [CH_W-1:0]         raw_dial;
   logic signed [OUT_W-1:0] ctr [4];
   logic signed [OUT_W-1:0] ctr_dial;

   assign push = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign func = func_type'(req_chan.func);

   // Accept while the skid register is free
   assign req_chan.ready = !skid_valid_ff;

   // Update burst count and silence age for the current event
   always_comb begin
      burst_in = burst_ff;
      age_in   = age_ff;
      byte_wr  = 1'b0;
      decode   = 1'b0;
      case (func)
         FUNC_BYTE: begin
            if (burst_ff < CountFull) begin
               burst_in = burst_ff + CountW'(1);
               byte_wr  = (burst_ff < CountFrame);
            end
         end
         FUNC_IDLE: begin
            decode   = (burst_ff == CountFrame);
            burst_in = '0;
            age_in   = '0;
         end
         FUNC_TICK: begin
            if (age_ff != AGE_MAX) begin
               age_in = age_ff + AGE_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Unpack the 11-bit channels from the stored frame
   assign raw[0]   = {frame_ff[1][2:0], frame_ff[0]};
   assign raw[1]   = {frame_ff[2][5:0], frame_ff[1][7:3]};
   assign raw[2]   = {frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]};
   assign raw[3]   = {frame_ff[5][3:0], frame_ff[4][7:1]};
   assign raw_dial = {frame_ff[17][2:0], frame_ff[16]};

   // Centre: raw minus center_value, modulo 2^12
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ctr[i] = signed'({1'b0, raw[i]} - {1'b0, center_ff});
      end
      ctr_dial = signed'({1'b0, raw_dial} - {1'b0, center_ff});
   end

   // Build the result from the state after this event
   always_comb begin
      result_in.frame_new    = decode;
      result_in.online       = (age_in < timeout_ff);
      result_in.stick_zero   = decode ? ctr[0] : stick_ff[0];
      result_in.stick_one    = decode ? ctr[1] : stick_ff[1];
      result_in.stick_two    = decode ? ctr[2] : stick_ff[2];
      result_in.stick_three  = decode ? ctr[3] : stick_ff[3];
      result_in.switch_left  = decode ? frame_ff[5][7:6] : switches_ff[3:2];
      result_in.switch_right = decode ? frame_ff[5][5:4] : switches_ff[1:0];
      result_in.dial_value   = decode ? ctr_dial : dial_ff;
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff  <= CENTER_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_VALUE:    center_ff  <= csr_wdata[CH_W-1:0];
            CSR_OFFLINE_TIMEOUT: timeout_ff <= csr_wdata[AGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Store received bytes of the frame
   always_ff @(posedge clock) begin
      if (push && byte_wr) begin
         frame_ff[burst_ff[FRAME_IDX_W-1:0]] <= req_chan.byte_value;
      end
   end

   // Advance burst count, silence age and held values
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff    <= '0;
         age_ff      <= '0;
         stick_ff    <= '{default: '0};
         switches_ff <= '0;
         dial_ff     <= '0;
      end else if (push) begin
         burst_ff <= burst_in;
         age_ff   <= age_in;
         if (decode) begin
            stick_ff[0] <= ctr[0];
            stick_ff[1] <= ctr[1];
            stick_ff[2] <= ctr[2];
            stick_ff[3] <= ctr[3];
            switches_ff <= frame_ff[5][7:4];
            dial_ff     <= ctr_dial;
         end
      end
   end

   // Result register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop && skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !pop) begin
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else begin
         out_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (out_valid_ff && !pop) begin
         if (push) begin
            skid_ff <= result_in;
         end
      end else if (push) begin
         out_ff <= result_in;
      end
   end

   // Drive the result channel
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_new    = out_ff.frame_new;
   assign rsp_chan.online       = out_ff.online;
   assign rsp_chan.stick_zero   = out_ff.stick_zero;
   assign rsp_chan.stick_one    = out_ff.stick_one;
   assign rsp_chan.stick_two    = out_ff.stick_two;
   assign rsp_chan.stick_three  = out_ff.stick_three;
   assign rsp_chan.switch_left  = out_ff.switch_left;
   assign rsp_chan.switch_right = out_ff.switch_right;
   assign rsp_chan.dial_value   = out_ff.dial_value;

   // Skid register is only filled behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid without result register");

   // Burst count never passes the buffer size
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      burst_ff <= CountFull)
      else $error("burst count beyond buffer size");

   // An accepted idle event restarts silence and clears the burst
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      (push && func == FUNC_IDLE) |=> (age_ff == '0 && burst_ff == '0))
      else $error("idle event did not clear burst and silence age");

   // A taken result with nothing behind it empties the buffer
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !skid_valid_ff && !push) |=> !out_valid_ff)
      else $error("result register not emptied after transfer");

endmodule
`default_nettype wire
